FILE: hdl/fpa_pkg.sv
// Package for the fixed-point ALU: word width, operation codes and the
// control record that travels down the divider row. No dependencies.
package fpa_pkg;

    localparam int WORD_W        = 32;
    localparam int FUNC_W        = 4;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DIV  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_GT   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_LT   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_GE   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_LE   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_EQ   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_NE   = 4'd9;
    localparam logic [FUNC_W-1:0] FN_MIN  = 4'd10;
    localparam logic [FUNC_W-1:0] FN_MAX  = 4'd11;
    localparam logic [FUNC_W-1:0] FN_INC  = 4'd12;
    localparam logic [FUNC_W-1:0] FN_DEC  = 4'd13;
    localparam logic [FUNC_W-1:0] FN_TOI  = 4'd14;
    localparam logic [FUNC_W-1:0] FN_FRI  = 4'd15;

    typedef struct packed {
        logic [WORD_W-1:0] fast;    // result of every non-divide operation
        logic              flag;
        logic              dz;
        logic              is_div;
        logic              neg;     // quotient sign
        logic [WORD_W-1:0] dvsr;    // divisor magnitude
    } t_ctl;

endpackage

FILE: hdl/fpa_if.sv
// Handshake interfaces for operand and result transactions.
// No dependencies.
interface fpa_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [31:0]          operand_a;
    logic signed [31:0]          operand_b;
    logic        [3:0]           func;
    modport source (output valid, operand_a, operand_b, func, input ready);
    modport sink   (input valid, operand_a, operand_b, func, output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               flag;
    logic               div_by_zero;
    modport source (output valid, result, flag, div_by_zero, input ready);
    modport sink   (input valid, result, flag, div_by_zero, output ready);
endinterface

FILE: hdl/fpa_prep.sv
// Front stage: all non-divide operations including the multiply, and operand
// magnitudes for the divider row. Depends on fpa_pkg.
module fpa_prep #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32 + FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_a,
    input  logic signed [31:0]    i_b,
    input  logic [3:0]            i_func,
    output logic                  o_valid,
    output fpa_pkg::t_ctl         o_ctl,
    output logic [DW-1:0]         o_num
);
    import fpa_pkg::*;

    logic                r_valid;
    t_ctl                r_ctl, n_ctl;
    logic [DW-1:0]       r_num, n_num;
    logic signed [63:0]  prod;
    logic signed [31:0]  sh;
    logic [31:0]         abs_a;

    always_comb begin
        prod  = i_a * i_b;
        sh    = i_a >>> FRAC_BITS;
        abs_a = i_a[31] ? 32'(-i_a) : i_a;
        n_ctl        = '0;
        n_ctl.neg    = i_a[31] ^ i_b[31];
        n_ctl.dvsr   = i_b[31] ? 32'(-i_b) : i_b;
        n_ctl.is_div = (i_func == FN_DIV);
        n_ctl.dz     = (i_func == FN_DIV) && (i_b == '0);
        n_num        = DW'(abs_a) << FRAC_BITS;
        case (i_func)
            FN_ADD: n_ctl.fast = i_a + i_b;
            FN_SUB: n_ctl.fast = i_a - i_b;
            FN_MUL: n_ctl.fast = prod[FRAC_BITS +: 32];
            FN_GT:  n_ctl.flag = i_a > i_b;
            FN_LT:  n_ctl.flag = i_a < i_b;
            FN_GE:  n_ctl.flag = i_a >= i_b;
            FN_LE:  n_ctl.flag = i_a <= i_b;
            FN_EQ:  n_ctl.flag = i_a == i_b;
            FN_NE:  n_ctl.flag = i_a != i_b;
            FN_MIN: n_ctl.fast = (i_a <= i_b) ? i_a : i_b;
            FN_MAX: n_ctl.fast = (i_a >= i_b) ? i_a : i_b;
            FN_INC: n_ctl.fast = i_a + 32'sd1;
            FN_DEC: n_ctl.fast = i_a - 32'sd1;
            FN_TOI: n_ctl.fast = sh;
            FN_FRI: n_ctl.fast = i_a << FRAC_BITS;
            default: n_ctl.fast = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctl <= n_ctl;
            r_num <= n_num;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_num   = r_num;
endmodule

FILE: hdl/fpa_div_cell.sv
// One restoring-division cell: takes one dividend bit, makes one quotient
// bit and hands everything to the next cell. Depends on fpa_pkg.
module fpa_div_cell #(
    parameter int DW = 32 + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  fpa_pkg::t_ctl   i_ctl,
    input  logic [DW-1:0]   i_num,
    input  logic [31:0]     i_rem,
    input  logic [31:0]     i_quo,
    output logic            o_valid,
    output fpa_pkg::t_ctl   o_ctl,
    output logic [DW-1:0]   o_num,
    output logic [31:0]     o_rem,
    output logic [31:0]     o_quo
);
    import fpa_pkg::*;

    logic          r_valid;
    t_ctl          r_ctl;
    logic [DW-1:0] r_num;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_quo, n_quo;
    logic [32:0]   rem_sh;
    logic [33:0]   diff;

    always_comb begin
        rem_sh = {i_rem, i_num[DW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_ctl.dvsr};
        // borrow means the divisor did not fit; remainder then stays below 2^32
        n_rem  = diff[33] ? rem_sh[31:0] : diff[31:0];
        n_quo  = {i_quo[30:0], ~diff[33]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctl <= i_ctl;
            r_num <= i_num << 1;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
endmodule

FILE: hdl/fixed_point_alu_unit.sv
// Fixed-point ALU top level: front stage, a row of 32+FRAC_BITS divider
// cells and an output register. Depends on fpa_pkg, fpa_if, fpa_prep, fpa_div_cell.
//
// Takes one transaction every cycle unless stalled and returns results in order.
// Every operation runs down the same pipeline (front stage, one cell per
// dividend bit of the shifted dividend, output register) for all codes;
// throughput is one transaction per cycle unless the pipeline holds.
// The whole pipeline holds while a result waits at the output and the sink
// is not ready. Division truncates toward zero; division by zero returns
// zero with div_by_zero set.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fpa_in_if.sink    i_op,
    fpa_out_if.source o_res
);
    import fpa_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    logic              en;
    logic              v   [DW+1];
    t_ctl              ctl [DW+1];
    logic [DW-1:0]     num [DW+1];
    logic [31:0]       rem [DW+1];
    logic [31:0]       quo [DW+1];

    logic              r_valid;
    logic [31:0]       r_result, n_result;
    logic              r_flag, r_dz;

    assign en         = !r_valid || o_res.ready;
    assign i_op.ready = en;

    fpa_prep #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_op.valid),
        .i_a     (i_op.operand_a),
        .i_b     (i_op.operand_b),
        .i_func  (i_op.func),
        .o_valid (v[0]),
        .o_ctl   (ctl[0]),
        .o_num   (num[0])
    );
    assign rem[0] = '0;
    assign quo[0] = '0;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        fpa_div_cell #(.DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_ctl   (ctl[g]),
            .i_num   (num[g]),
            .i_rem   (rem[g]),
            .i_quo   (quo[g]),
            .o_valid (v[g+1]),
            .o_ctl   (ctl[g+1]),
            .o_num   (num[g+1]),
            .o_rem   (rem[g+1]),
            .o_quo   (quo[g+1])
        );
    end

    always_comb begin
        if (!ctl[DW].is_div) begin
            n_result = ctl[DW].fast;
        end else if (ctl[DW].dz) begin
            n_result = '0;
        end else if (ctl[DW].neg) begin
            n_result = -quo[DW];
        end else begin
            n_result = quo[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= v[DW];
        end
        if (en) begin
            r_result <= n_result;
            r_flag   <= ctl[DW].flag;
            r_dz     <= ctl[DW].dz;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.result      = r_result;
    assign o_res.flag        = r_flag;
    assign o_res.div_by_zero = r_dz;
endmodule

FILE: tb/testbench.sv
// Self-checking bench for fixed_point_alu_unit: directed table then random operand
// transactions, each result checked against its table entry or a local
// fixed-point predictor. Depends on fpa_pkg, fpa_if and the ALU RTL.
module testbench;
    import fpa_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int N_RANDOM   = 1850;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = FB + 40;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [3:0]         fn;
    } t_opnd;

    typedef struct {
        logic [31:0] res;
        logic        flag;
        logic        dz;
    } t_alu_res;

    typedef struct {
        t_opnd    op;
        bit       typed;    // expected result given in the table
        t_alu_res want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    fpa_in_if  op_if ();
    fpa_out_if res_if ();

    fixed_point_alu_unit #(.FRAC_BITS(FB)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if),
        .o_res   (res_if)
    );

    always #4 i_clk = ~i_clk;

    t_alu_res pending_res[$];
    int       fail_cnt = 0;
    longint   cycle_cnt = 0;
    bit       sink_stall_on = 1'b1;

    function automatic t_alu_res alu_predict(t_opnd op);
        t_alu_res    r;
        longint      a64, b64, p;
        logic [63:0] q;
        a64 = op.a;
        b64 = op.b;
        r = '{res: '0, flag: 1'b0, dz: 1'b0};
        case (op.fn)
            FN_ADD: r.res = 32'(a64 + b64);
            FN_SUB: r.res = 32'(a64 - b64);
            FN_MUL: begin
                p = a64 * b64;
                r.res = 32'(p >>> FB);
            end
            FN_DIV: begin
                if (b64 == 0) r.dz = 1'b1;
                else begin
                    q = (a64 * (64'sd1 <<< FB)) / b64;
                    r.res = q[31:0];
                end
            end
            FN_GT:  r.flag = a64 >  b64;
            FN_LT:  r.flag = a64 <  b64;
            FN_GE:  r.flag = a64 >= b64;
            FN_LE:  r.flag = a64 <= b64;
            FN_EQ:  r.flag = a64 == b64;
            FN_NE:  r.flag = a64 != b64;
            FN_MIN: r.res = (a64 <= b64) ? op.a : op.b;
            FN_MAX: r.res = (a64 >= b64) ? op.a : op.b;
            FN_INC: r.res = 32'(a64 + 1);
            FN_DEC: r.res = 32'(a64 - 1);
            FN_TOI: r.res = 32'(a64 >>> FB);
            default: r.res = 32'(a64 <<< FB);
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)  return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 ^ $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return 32'($urandom_range(0, 1)) - 32'd1 + 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(t_opnd op, t_alu_res want);
        op_if.valid     <= 1'b1;
        op_if.operand_a <= op.a;
        op_if.operand_b <= op.b;
        op_if.func      <= op.fn;
        @(posedge i_clk);
        while (!op_if.ready) @(posedge i_clk);
        pending_res.push_back(want);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            op_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // sink side: random back-pressure, stretches with none
    always @(posedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else if (!sink_stall_on) res_if.ready <= 1'b1;
        else res_if.ready <= ($urandom_range(0, 3) != 0) ||
                             ($urandom_range(0, 9) == 0);
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) sink_stall_on <= ~sink_stall_on;
    end

    always @(posedge i_clk) begin
        t_alu_res w;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %h", $time, res_if.result);
                fail_cnt++;
            end else begin
                w = pending_res.pop_front();
                if (w.res !== res_if.result || w.flag !== res_if.flag ||
                    w.dz !== res_if.div_by_zero) begin
                    $display("%0t: mismatch exp res=%h flag=%b dz=%b act res=%h flag=%b dz=%b",
                             $time, w.res, w.flag, w.dz,
                             res_if.result, res_if.flag, res_if.div_by_zero);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    t_row dir_rows[] = '{
        '{'{32'sh7FFF_FFFF, 32'sd1, FN_ADD}, 1, '{32'h8000_0000, 0, 0}},
        '{'{32'sh8000_0000, 32'sd1, FN_SUB}, 1, '{32'h7FFF_FFFF, 0, 0}},
        '{'{32'sh0000_0200, 32'sh0000_0300, FN_MUL}, 1, '{32'h0000_0600, 0, 0}},
        '{'{32'sh8000_0000, 32'sh8000_0000, FN_MUL}, 0, '{0, 0, 0}},
        '{'{32'sh0000_0100, 32'sd0, FN_DIV}, 1, '{32'h0, 0, 1}},
        '{'{32'sh8000_0000, 32'sd0, FN_DIV}, 1, '{32'h0, 0, 1}},
        '{'{32'sh8000_0000, -32'sd1, FN_DIV}, 0, '{0, 0, 0}},
        '{'{-32'sd7, 32'sh0000_0200, FN_DIV}, 0, '{0, 0, 0}},
        '{'{32'sh7FFF_FFFF, 32'sh8000_0000, FN_GT}, 1, '{32'h0, 1, 0}},
        '{'{32'sh7FFF_FFFF, 32'sh8000_0000, FN_LT}, 1, '{32'h0, 0, 0}},
        '{'{32'sd5, 32'sd5, FN_GE}, 1, '{32'h0, 1, 0}},
        '{'{32'sd5, 32'sd5, FN_LE}, 1, '{32'h0, 1, 0}},
        '{'{-32'sd1, -32'sd1, FN_EQ}, 1, '{32'h0, 1, 0}},
        '{'{-32'sd1, -32'sd1, FN_NE}, 1, '{32'h0, 0, 0}},
        '{'{32'sh8000_0000, 32'sh7FFF_FFFF, FN_MIN}, 1, '{32'h8000_0000, 0, 0}},
        '{'{32'sh8000_0000, 32'sh7FFF_FFFF, FN_MAX}, 1, '{32'h7FFF_FFFF, 0, 0}},
        '{'{32'sh7FFF_FFFF, 32'sh1234_5678, FN_INC}, 1, '{32'h8000_0000, 0, 0}},
        '{'{32'sh8000_0000, -32'sd1, FN_DEC}, 1, '{32'h7FFF_FFFF, 0, 0}},
        '{'{32'sh8000_0000, 32'sd0, FN_TOI}, 0, '{0, 0, 0}},
        '{'{-32'sd1, 32'sd9, FN_TOI}, 1, '{32'hFFFF_FFFF, 0, 0}},
        '{'{32'sh7FFF_FFFF, 32'sd3, FN_FRI}, 0, '{0, 0, 0}},
        '{'{32'sd3, -32'sd1, FN_FRI}, 0, '{0, 0, 0}}
    };

    initial begin
        t_opnd    op;
        t_alu_res w;
        op_if.valid     <= 1'b0;
        op_if.operand_a <= '0;
        op_if.operand_b <= '0;
        op_if.func      <= FN_ADD;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            w = dir_rows[i].typed ? dir_rows[i].want : alu_predict(dir_rows[i].op);
            send_op(dir_rows[i].op, w);
            pause(gap_len());
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            op.a  = rand_word();
            op.b  = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
            op.fn = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0) op.b = op.a;
            send_op(op, alu_predict(op));
            pause(gap_len());
        end
        op_if.valid <= 1'b0;

        while (pending_res.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
